FILE: sv/rvt_pkg.sv
package rvt_pkg;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DRD  = 6'b000010,
    S_DCMP = 6'b000100,
    S_VRD  = 6'b001000,
    S_VCMP = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } del_ctl_t;

  localparam logic [2:0] ACT_APPEND   = 3'd0;
  localparam logic [2:0] ACT_RESTAMP  = 3'd1;
  localparam logic [2:0] ACT_DELETE   = 3'd2;
  localparam logic [2:0] ACT_UNDELETE = 3'd3;
  localparam logic [2:0] ACT_CHECK    = 3'd4;
  localparam logic [2:0] ACT_COUNT_AT = 3'd5;
  localparam logic [2:0] ACT_COMMIT   = 3'd6;
  localparam logic [2:0] ACT_CFU      = 3'd7;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_CONFLICT  = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  localparam logic [13:0] ROWS_RESET = 14'd8192;

endpackage

FILE: sv/rvt_del_store.sv
module rvt_del_store #(
  parameter int ROW_CAPACITY = 8192
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rvt_pkg::del_ctl_t               ctl,
  input  logic [$clog2(ROW_CAPACITY)-1:0] addr,
  input  logic [63:0]                     wdata,
  output logic [63:0]                     rdata,
  output logic                            busy
);

  localparam int RW = $clog2(ROW_CAPACITY);

  logic [63:0] mem [ROW_CAPACITY];
  logic [RW:0] clr_cnt_r;
  logic [63:0] rdata_r;

  assign busy  = !clr_cnt_r[RW];
  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (busy) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_cnt_r[RW-1:0]] <= '0;
    end else if (ctl.wr_en) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata_r <= mem[addr];
    end
  end

endmodule

FILE: sv/row_version_table.sv
// Row version table for one storage block.
// Items enter on the in_ channel: in_tuser carries the action, in_tdata the
// stamps, the cumulative row count and the row offset. Each item yields one
// result item on the out_ channel, with the status in out_tuser and the row
// figures and deleted flag in out_tdata.
// Delete, undelete and check read the delete memory once, in S_DRD, and decide
// in S_DCMP; a row out of range skips the read and gets ST_RANGE. Append goes
// from acceptance straight to S_DONE. Restamp, count_at and commit_rows scan
// the version memory from the first entry, with one read in S_VRD and one
// compare in S_VCMP per entry, and stop at the first entry that settles them
// or after the last. count_for_update reads the last entry only, or goes
// straight to S_DONE on an empty list.
// One item is in work at a time; the next is accepted from the cycle after the
// result has moved to the output register, even while that result waits.
// After reset the delete memory is cleared one row per cycle; while it clears,
// in_tready stays low; cfg writes are always taken.
// When the receiver stalls, a second finished result waits inside the block
// and no further item is accepted until the output register frees up.
module row_version_table #(
  parameter int ROW_CAPACITY = 8192,
  parameter int MAX_VERSIONS = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [63:0] stamp, [127:64] new_stamp, [141:128] cumulative_rows,
  // [154:142] row_index, [159:155] zero
  input  logic [159:0] in_tdata,
  // [2:0] action
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [13:0] first_row, [27:14] row_total, [28] is_deleted, [31:29] zero
  output logic [31:0]  out_tdata,
  // [1:0] status
  output logic [1:0]   out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [13:0]  cfg_data
);

  localparam int RW = $clog2(ROW_CAPACITY);
  localparam int VA = $clog2(MAX_VERSIONS);
  localparam int VW = VA + 1;
  localparam int LW = (RW + 1 > 14) ? RW + 1 : 14;

  rvt_pkg::state_t state_r, state_nxt;

  logic [63:0] vstamp_mem [MAX_VERSIONS];
  logic [13:0] vtotal_mem [MAX_VERSIONS];
  logic [63:0] vstamp_q;
  logic [13:0] vtotal_q;
  logic        vrd_en;
  logic        vwr_en;
  logic        vwr_total;
  logic [VA-1:0] vwr_addr;
  logic [63:0] vwr_stamp;

  logic [VW-1:0] count_r, count_nxt;
  logic [VW-1:0] idx_r, idx_nxt;
  logic [13:0]   prev_r, prev_nxt;
  logic [13:0]   rows_r;

  logic [2:0]  act_r, act_nxt;
  logic [63:0] stamp_r, stamp_nxt;
  logic [63:0] new_stamp_r, new_stamp_nxt;
  logic [12:0] row_r, row_nxt;

  logic [1:0]  res_status_r, res_status_nxt;
  logic [13:0] res_first_r, res_first_nxt;
  logic [13:0] res_total_r, res_total_nxt;
  logic        res_del_r, res_del_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic [13:0] out_first_r, out_first_nxt;
  logic [13:0] out_total_r, out_total_nxt;
  logic        out_del_r, out_del_nxt;

  rvt_pkg::del_ctl_t del_ctl;
  logic [63:0] del_wdata;
  logic [63:0] del_rdata;
  logic        del_busy;

  logic [2:0]  in_act;
  logic [63:0] in_stamp;
  logic [63:0] in_new_stamp;
  logic [13:0] in_cum;
  logic [12:0] in_row;
  logic        in_fire;
  logic [LW-1:0] lim;
  logic        row_ok;

  assign in_act       = in_tuser;
  assign in_stamp     = in_tdata[63:0];
  assign in_new_stamp = in_tdata[127:64];
  assign in_cum       = in_tdata[141:128];
  assign in_row       = in_tdata[154:142];

  assign in_tready = (state_r == rvt_pkg::S_IDLE) && !del_busy;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {3'b000, out_del_r, out_total_r, out_first_r};

  assign lim = (LW'(rows_r) < LW'(ROW_CAPACITY)) ? LW'(rows_r) : LW'(ROW_CAPACITY);
  assign row_ok = LW'(row_r) < lim;

  rvt_del_store #(
    .ROW_CAPACITY(ROW_CAPACITY)
  ) u_del (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (del_ctl),
    .addr (RW'(row_r)),
    .wdata(del_wdata),
    .rdata(del_rdata),
    .busy (del_busy)
  );

  always_ff @(posedge clk) begin
    if (vwr_en) begin
      vstamp_mem[vwr_addr] <= vwr_stamp;
      if (vwr_total) begin
        vtotal_mem[vwr_addr] <= in_cum;
      end
    end
    if (vrd_en) begin
      vstamp_q <= vstamp_mem[idx_r[VA-1:0]];
      vtotal_q <= vtotal_mem[idx_r[VA-1:0]];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    prev_nxt       = prev_r;
    act_nxt        = act_r;
    stamp_nxt      = stamp_r;
    new_stamp_nxt  = new_stamp_r;
    row_nxt        = row_r;
    res_status_nxt = res_status_r;
    res_first_nxt  = res_first_r;
    res_total_nxt  = res_total_r;
    res_del_nxt    = res_del_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_first_nxt  = out_first_r;
    out_total_nxt  = out_total_r;
    out_del_nxt    = out_del_r;
    vrd_en         = 1'b0;
    vwr_en         = 1'b0;
    vwr_total      = 1'b0;
    vwr_addr       = count_r[VA-1:0];
    vwr_stamp      = in_stamp;
    del_ctl        = '0;
    del_wdata      = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      rvt_pkg::S_IDLE: begin
        if (in_fire) begin
          act_nxt        = in_act;
          stamp_nxt      = in_stamp;
          new_stamp_nxt  = in_new_stamp;
          row_nxt        = in_row;
          res_status_nxt = rvt_pkg::ST_OK;
          res_first_nxt  = '0;
          res_total_nxt  = '0;
          res_del_nxt    = 1'b0;
          idx_nxt        = '0;
          prev_nxt       = '0;
          unique case (in_act)
            rvt_pkg::ACT_APPEND: begin
              if (count_r == VW'(MAX_VERSIONS)) begin
                res_status_nxt = rvt_pkg::ST_RANGE;
              end else begin
                vwr_en    = 1'b1;
                vwr_total = 1'b1;
                count_nxt = count_r + 1'b1;
              end
              state_nxt = rvt_pkg::S_DONE;
            end
            rvt_pkg::ACT_DELETE, rvt_pkg::ACT_UNDELETE, rvt_pkg::ACT_CHECK: begin
              state_nxt = rvt_pkg::S_DRD;
            end
            rvt_pkg::ACT_CFU: begin
              if (count_r == '0) begin
                state_nxt = rvt_pkg::S_DONE;
              end else begin
                idx_nxt   = count_r - 1'b1;
                state_nxt = rvt_pkg::S_VRD;
              end
            end
            default: begin
              state_nxt = rvt_pkg::S_VRD;
            end
          endcase
        end
      end
      rvt_pkg::S_DRD: begin
        if (row_ok) begin
          del_ctl.rd_en = 1'b1;
          state_nxt     = rvt_pkg::S_DCMP;
        end else begin
          res_status_nxt = rvt_pkg::ST_RANGE;
          state_nxt      = rvt_pkg::S_DONE;
        end
      end
      rvt_pkg::S_DCMP: begin
        priority case (act_r)
          rvt_pkg::ACT_DELETE: begin
            if (del_rdata != '0) begin
              res_status_nxt = rvt_pkg::ST_CONFLICT;
            end else begin
              del_ctl.wr_en = 1'b1;
              del_wdata     = stamp_r;
            end
          end
          rvt_pkg::ACT_UNDELETE: begin
            del_ctl.wr_en = 1'b1;
          end
          default: begin
            res_del_nxt = (del_rdata != '0) && (del_rdata <= stamp_r);
          end
        endcase
        state_nxt = rvt_pkg::S_DONE;
      end
      rvt_pkg::S_VRD: begin
        if (idx_r < count_r) begin
          vrd_en    = 1'b1;
          state_nxt = rvt_pkg::S_VCMP;
        end else begin
          if (act_r == rvt_pkg::ACT_COUNT_AT) begin
            res_total_nxt = prev_r;
          end else begin
            res_status_nxt = rvt_pkg::ST_NOT_FOUND;
          end
          state_nxt = rvt_pkg::S_DONE;
        end
      end
      rvt_pkg::S_VCMP: begin
        state_nxt = rvt_pkg::S_VRD;
        idx_nxt   = idx_r + 1'b1;
        prev_nxt  = vtotal_q;
        priority case (act_r)
          rvt_pkg::ACT_RESTAMP: begin
            if (vstamp_q == stamp_r) begin
              vwr_en    = 1'b1;
              vwr_addr  = idx_r[VA-1:0];
              vwr_stamp = new_stamp_r;
              state_nxt = rvt_pkg::S_DONE;
            end
          end
          rvt_pkg::ACT_COUNT_AT: begin
            if (vstamp_q > stamp_r) begin
              res_total_nxt = prev_r;
              state_nxt     = rvt_pkg::S_DONE;
            end
          end
          rvt_pkg::ACT_COMMIT: begin
            if (vstamp_q >= stamp_r) begin
              if ((vstamp_q == stamp_r) && (stamp_r != '1)) begin
                res_first_nxt = prev_r;
                res_total_nxt = (vtotal_q >= prev_r) ? vtotal_q - prev_r : '0;
              end else begin
                res_status_nxt = rvt_pkg::ST_NOT_FOUND;
              end
              state_nxt = rvt_pkg::S_DONE;
            end
          end
          default: begin
            if (vstamp_q >= stamp_r) begin
              res_status_nxt = rvt_pkg::ST_CONFLICT;
            end else begin
              res_total_nxt = vtotal_q;
            end
            state_nxt = rvt_pkg::S_DONE;
          end
        endcase
      end
      rvt_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_first_nxt  = res_first_r;
          out_total_nxt  = res_total_r;
          out_del_nxt    = res_del_r;
          state_nxt      = rvt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rvt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rvt_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      rows_r      <= rvt_pkg::ROWS_RESET;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        rows_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    prev_r       <= prev_nxt;
    act_r        <= act_nxt;
    stamp_r      <= stamp_nxt;
    new_stamp_r  <= new_stamp_nxt;
    row_r        <= row_nxt;
    res_status_r <= res_status_nxt;
    res_first_r  <= res_first_nxt;
    res_total_r  <= res_total_nxt;
    res_del_r    <= res_del_nxt;
    out_status_r <= out_status_nxt;
    out_first_r  <= out_first_nxt;
    out_total_r  <= out_total_nxt;
    out_del_r    <= out_del_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= VW'(MAX_VERSIONS))
    else $error("version count exceeds the list size");

  a_fire_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != rvt_pkg::S_IDLE)
    else $error("accepted item did not start work");

  a_vread_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    vrd_en |-> idx_r < count_r)
    else $error("version read beyond the list");

  a_done_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rvt_pkg::S_DONE && !out_valid_r) |=> out_valid_r)
    else $error("finished result not moved to the output");

endmodule
